>>> rtl/csum_pkg.sv
package csum_pkg;

  localparam int VALUE_BITS = 32;
  localparam int SUM_BITS   = VALUE_BITS + 12;
  localparam int COUNT_BITS = 13;
  localparam int TOTAL_BITS = 24;
  localparam int EPOCH_BITS = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] element_value;
    logic                         last_item;
  } in_beat_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] ending_here;
    logic [TOTAL_BITS-1:0] running_total;
    logic                  table_overflow;
    logic                  sequence_end;
  } out_beat_t;

  // table slot: tag equal to the live epoch marks a slot in use
  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [SUM_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic key_want;
    logic key_prefix;
    logic hash_load;
    logic mem_rd;
    logic probe_next;
    logic take_here;
    logic wr_hit;
    logic wr_new;
    logic set_ovf;
    logic clr_wr;
    logic seed_wr;
    logic seq_end;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic exhausted;
    logic clr_last;
    logic epoch_wrap;
    logic last_item;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/csum_ctrl.sv
module csum_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  csum_pkg::stat_t sts,
  output csum_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_SEED  = 8'b0000_0010,
    ST_IDLE  = 8'b0000_0100,
    ST_WKEY  = 8'b0000_1000,
    ST_HASH  = 8'b0001_0000,
    ST_READ  = 8'b0010_0000,
    ST_LOOK  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;  // 0: lookup of prefix - target, 1: update of prefix

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        cmd.seed_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_WKEY;
        end
      end
      ST_WKEY: begin
        cmd.key_want = 1'b1;
        phase_nxt    = 1'b0;
        state_nxt    = ST_HASH;
      end
      ST_HASH: begin
        cmd.hash_load = 1'b1;
        state_nxt     = ST_READ;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_LOOK;
      end
      ST_LOOK: begin
        if (!phase_r) begin
          if (sts.hit || sts.empty || sts.exhausted) begin
            cmd.take_here  = 1'b1;
            cmd.key_prefix = 1'b1;
            phase_nxt      = 1'b1;
            state_nxt      = ST_HASH;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = ST_READ;
          end
        end else begin
          priority if (sts.hit) begin
            cmd.wr_hit = 1'b1;
            state_nxt  = ST_DONE;
          end else if (sts.empty) begin
            cmd.wr_new = 1'b1;
            state_nxt  = ST_DONE;
          end else if (sts.exhausted) begin
            cmd.set_ovf = 1'b1;
            state_nxt   = ST_DONE;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.last_item) begin
            cmd.seq_end = 1'b1;
            state_nxt   = sts.epoch_wrap ? ST_CLEAR : ST_SEED;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> rtl/csum_dp.sv
module csum_dp #(
  parameter int MAX_ITEMS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  csum_pkg::in_beat_t                   in_data,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic signed [csum_pkg::VALUE_BITS-1:0] cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output csum_pkg::out_beat_t                  out_data,
  input  csum_pkg::cmd_t                       cmd,
  output csum_pkg::stat_t                      sts
);

  localparam int IDX_BITS = $clog2(MAX_ITEMS);
  localparam int PRB_BITS = $clog2(MAX_ITEMS + 1);
  localparam logic [IDX_BITS:0]   DEPTH    = MAX_ITEMS[IDX_BITS:0];
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_ITEMS - 1);
  localparam logic [PRB_BITS-1:0] PRB_MAX  = PRB_BITS'(MAX_ITEMS);
  localparam int SB = csum_pkg::SUM_BITS;
  localparam int VB = csum_pkg::VALUE_BITS;

  // fold the key onto the index width, then bring it below the depth
  function automatic logic [IDX_BITS-1:0] hash_f(input logic [SB-1:0] k);
    logic [IDX_BITS-1:0] acc;
    acc = '0;
    for (int i = 0; i < SB; i++) begin
      acc[i % IDX_BITS] = acc[i % IDX_BITS] ^ k[i];
    end
    if ({1'b0, acc} >= DEPTH) begin
      acc = IDX_BITS'({1'b0, acc} - DEPTH);
    end
    return acc;
  endfunction

  csum_pkg::entry_t mem [MAX_ITEMS];
  csum_pkg::entry_t rdata_r;

  logic signed [VB-1:0]             target_r;
  logic [SB-1:0]                    prefix_r;
  logic [SB-1:0]                    key_r;
  logic [IDX_BITS-1:0]              addr_r;
  logic [IDX_BITS-1:0]              clr_idx_r;
  logic [PRB_BITS-1:0]              probes_r;
  logic [csum_pkg::EPOCH_BITS-1:0]  epoch_r;
  logic [csum_pkg::COUNT_BITS-1:0]  here_r;
  logic [csum_pkg::TOTAL_BITS-1:0]  total_r;
  logic                             ovf_r;
  logic                             last_r;
  logic                             out_valid_r;
  csum_pkg::out_beat_t              out_r;

  logic [SB-1:0]                    elem_ext;
  logic [SB-1:0]                    tgt_ext;
  logic [csum_pkg::COUNT_BITS-1:0]  here_nxt;
  logic [csum_pkg::TOTAL_BITS:0]    total_sum;
  logic                             we;
  logic [IDX_BITS-1:0]              waddr;
  csum_pkg::entry_t                 wdata;

  assign elem_ext = {{(SB-VB){in_data.element_value[VB-1]}}, in_data.element_value};
  assign tgt_ext  = {{(SB-VB){target_r[VB-1]}}, target_r};

  assign sts.hit        = (rdata_r.tag == epoch_r) && (rdata_r.key == key_r);
  assign sts.empty      = (rdata_r.tag != epoch_r);
  assign sts.exhausted  = (probes_r == PRB_MAX);
  assign sts.clr_last   = (clr_idx_r == LAST_IDX);
  assign sts.epoch_wrap = (epoch_r == csum_pkg::EPOCH_LAST);
  assign sts.last_item  = last_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign here_nxt  = sts.hit ? rdata_r.count : '0;
  assign total_sum = {1'b0, total_r} + {{(csum_pkg::TOTAL_BITS+1-csum_pkg::COUNT_BITS){1'b0}},
                                        here_nxt};

  always_comb begin
    we    = cmd.clr_wr | cmd.seed_wr | cmd.wr_hit | cmd.wr_new;
    waddr = addr_r;
    wdata = '0;
    priority if (cmd.clr_wr) begin
      waddr = clr_idx_r;
    end else if (cmd.seed_wr) begin
      waddr       = hash_f('0);
      wdata.tag   = epoch_r;
      wdata.count = csum_pkg::COUNT_BITS'(1);
    end else if (cmd.wr_hit) begin
      wdata.tag   = epoch_r;
      wdata.key   = key_r;
      wdata.count = (rdata_r.count == csum_pkg::COUNT_MAX) ? rdata_r.count
                                                             : rdata_r.count + 1'b1;
    end else begin
      wdata.tag   = epoch_r;
      wdata.key   = key_r;
      wdata.count = csum_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end else if (cmd.mem_rd) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_r <= in_data.last_item;
    end
    if (cmd.key_want) begin
      key_r <= prefix_r - tgt_ext;
    end else if (cmd.key_prefix) begin
      key_r <= prefix_r;
    end
    if (cmd.hash_load) begin
      addr_r <= hash_f(key_r);
    end else if (cmd.probe_next) begin
      addr_r <= (addr_r == LAST_IDX) ? '0 : addr_r + 1'b1;
    end
    if (cmd.take_here) begin
      here_r <= here_nxt;
    end
    if (cmd.out_load) begin
      out_r.ending_here    <= here_r;
      out_r.running_total  <= total_r;
      out_r.table_overflow <= ovf_r;
      out_r.sequence_end   <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      prefix_r    <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      epoch_r     <= csum_pkg::EPOCH_FIRST;
      clr_idx_r   <= '0;
      probes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_data;
      end
      if (cmd.accept) begin
        prefix_r <= prefix_r + elem_ext;
      end
      if (cmd.hash_load) begin
        probes_r <= PRB_BITS'(1);
      end else if (cmd.probe_next) begin
        probes_r <= probes_r + 1'b1;
      end
      if (cmd.take_here) begin
        total_r <= total_sum[csum_pkg::TOTAL_BITS] ? csum_pkg::TOTAL_MAX
                                                   : total_sum[csum_pkg::TOTAL_BITS-1:0];
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.clr_wr) begin
        clr_idx_r <= (clr_idx_r == LAST_IDX) ? '0 : clr_idx_r + 1'b1;
      end
      if (cmd.seq_end) begin
        prefix_r <= '0;
        total_r  <= '0;
        ovf_r    <= 1'b0;
        epoch_r  <= (epoch_r == csum_pkg::EPOCH_LAST) ? csum_pkg::EPOCH_FIRST
                                                      : epoch_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/count_subarrays_with_sum_top.sv
// Sequence: an accepted beat passes ST_WKEY, then ST_HASH, ST_READ and ST_LOOK for the lookup,
//   ST_HASH, ST_READ and ST_LOOK again for the update, one more ST_READ and ST_LOOK per further
//   slot probed, then ST_DONE, which loads the output register; the input stays stalled meanwhile,
//   and the single-port table memory is read once per probe. After each last_item the table is reseeded.
// Reset: synchronous, rst_n low. After reset the table is swept slot by slot (input stalled),
//   and again after every 255th sequence when the epoch tag wraps.
module count_subarrays_with_sum_top #(
  parameter int MAX_ITEMS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  csum_pkg::in_beat_t                    in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output csum_pkg::out_beat_t                   out_data,
  // target_sum register write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic signed [csum_pkg::VALUE_BITS-1:0] cfg_data
);

  // Controller walks each beat through: lookup of (prefix - target) with linear
  // probing, then insert or increment of the new prefix (or the overflow flag when
  // the table is full), then hand-off to the output register. The output register
  // lets the next beat in while a result still waits downstream.
  csum_pkg::cmd_t  cmd;
  csum_pkg::stat_t sts;

  // Target register is always writable; the user must keep writes between beats, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  csum_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath holds the hash table (epoch-tagged slots), prefix, total and flags.
  csum_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
